[design/fxa_pkg.sv]
// types and constants for the q24.8 fixed-point alu
// no dependencies
`timescale 1ns / 1ps

package fxa_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 8;
  localparam int NUM_W  = DATA_W + FRAC_W;
  localparam int PROD_W = 2 * DATA_W;
  localparam int DIV_STEPS = NUM_W;

  localparam logic signed [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    KIND_ADD     = 4'd0,
    KIND_SUB     = 4'd1,
    KIND_MUL     = 4'd2,
    KIND_DIV     = 4'd3,
    KIND_EQ      = 4'd4,
    KIND_NE      = 4'd5,
    KIND_LT      = 4'd6,
    KIND_LE      = 4'd7,
    KIND_GT      = 4'd8,
    KIND_GE      = 4'd9,
    KIND_MIN     = 4'd10,
    KIND_MAX     = 4'd11,
    KIND_INC     = 4'd12,
    KIND_DEC     = 4'd13,
    KIND_TOINT   = 4'd14,
    KIND_FROMINT = 4'd15
  } fxa_kind_e;

  typedef struct packed {
    fxa_kind_e                 kind;
    logic signed [DATA_W-1:0]  res;
    logic                      cmp;
    logic                      ov;
    logic                      neg;
    logic                      divz;
    logic [DATA_W-1:0]         mag_a;
    logic [DATA_W-1:0]         mag_b;
    logic [PROD_W-1:0]         prod;
    logic [DATA_W-1:0]         rem;
    logic [NUM_W-1:0]          quo;
    logic [NUM_W-1:0]          num;
  } fxa_data_t;

endpackage

[design/fxa_req_if.sv]
// request channel of the fixed-point alu
// depends on fxa_pkg
`timescale 1ns / 1ps

interface fxa_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [3:0]                           kind;
  logic signed [fxa_pkg::DATA_W-1:0]    operand_a;
  logic signed [fxa_pkg::DATA_W-1:0]    operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

[design/fxa_rsp_if.sv]
// result channel of the fixed-point alu
// depends on fxa_pkg
`timescale 1ns / 1ps

interface fxa_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fxa_pkg::DATA_W-1:0]    result;
  logic                                 compare_true;
  logic                                 overflow;

  modport source (output valid, result, compare_true, overflow, input ready);
  modport sink (input valid, result, compare_true, overflow, output ready);
endinterface

[design/fxa_front.sv]
// input stage: decode, simple operations, operand magnitudes
// depends on fxa_pkg and fxa_req_if
`timescale 1ns / 1ps

module fxa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  fxa_req_if.sink           req_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fxa_pkg::fxa_data_t data_o
);
  import fxa_pkg::*;

  function automatic logic [DATA_W:0] sat_w(input logic [DATA_W:0] v);
    logic [DATA_W:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = {1'b1, (v[DATA_W] ? MIN_V : MAX_V)};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  logic              v_q;
  fxa_data_t         d_q;
  fxa_data_t         d_d;
  logic signed [DATA_W-1:0] a, b;
  logic [DATA_W:0]   a_x, b_x, s_w;
  fxa_kind_e         kind;

  assign a = req_i.operand_a;
  assign b = req_i.operand_b;
  assign a_x = {a[DATA_W-1], a};
  assign b_x = {b[DATA_W-1], b};
  assign kind = fxa_kind_e'(req_i.kind);

  always_comb begin
    d_d = '0;
    s_w = '0;
    d_d.kind = kind;
    d_d.neg = a[DATA_W-1] ^ b[DATA_W-1];
    d_d.divz = (b == '0);
    d_d.mag_a = a[DATA_W-1] ? DATA_W'(-a) : a;
    d_d.mag_b = b[DATA_W-1] ? DATA_W'(-b) : b;
    d_d.num = {d_d.mag_a, {FRAC_W{1'b0}}};
    case (kind)
      KIND_ADD: s_w = sat_w(a_x + b_x);
      KIND_SUB: s_w = sat_w(a_x - b_x);
      KIND_INC: s_w = sat_w(a_x + (DATA_W+1)'(1));
      KIND_DEC: s_w = sat_w(a_x - (DATA_W+1)'(1));
      KIND_DIV: begin
        if (b == '0) s_w = {1'b1, (a[DATA_W-1] ? MIN_V : MAX_V)};
      end
      KIND_EQ: d_d.cmp = (a == b);
      KIND_NE: d_d.cmp = (a != b);
      KIND_LT: d_d.cmp = (a < b);
      KIND_LE: d_d.cmp = (a <= b);
      KIND_GT: d_d.cmp = (a > b);
      KIND_GE: d_d.cmp = (a >= b);
      KIND_MIN: s_w = {1'b0, ((a > b) ? b : a)};
      KIND_MAX: s_w = {1'b0, ((a > b) ? a : b)};
      KIND_TOINT: s_w = {1'b0, (a >>> FRAC_W)};
      KIND_FROMINT: begin
        if (!a[DATA_W-1] && (a[DATA_W-2:DATA_W-1-FRAC_W] != '0)) begin
          s_w = {1'b1, MAX_V};
        end else if (a[DATA_W-1] && (a[DATA_W-2:DATA_W-1-FRAC_W] != '1)) begin
          s_w = {1'b1, MIN_V};
        end else begin
          s_w = {1'b0, (a <<< FRAC_W)};
        end
      end
      default: s_w = '0;
    endcase
    d_d.ov = s_w[DATA_W];
    d_d.res = s_w[DATA_W-1:0];
  end

  assign req_i.ready = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (req_i.ready) begin
      v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o = d_q;
endmodule

[design/fxa_mul.sv]
// multiplier stage: product of the operand magnitudes
// depends on fxa_pkg
`timescale 1ns / 1ps

module fxa_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  fxa_pkg::fxa_data_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output fxa_pkg::fxa_data_t data_o
);
  import fxa_pkg::*;

  logic      v_q;
  fxa_data_t d_q;
  fxa_data_t d_d;

  always_comb begin
    d_d = data_i;
    d_d.prod = data_i.mag_a * data_i.mag_b;
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o = d_q;
endmodule

[design/fxa_div_step.sv]
// one restoring division step: one quotient bit per stage
// depends on fxa_pkg
`timescale 1ns / 1ps

module fxa_div_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  fxa_pkg::fxa_data_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output fxa_pkg::fxa_data_t data_o
);
  import fxa_pkg::*;

  logic            v_q;
  fxa_data_t       d_q;
  fxa_data_t       d_d;
  logic [DATA_W:0] trial;
  logic [DATA_W:0] diff;
  logic            qbit;

  always_comb begin
    d_d = data_i;
    trial = {data_i.rem, data_i.num[NUM_W-1]};
    diff = trial - {1'b0, data_i.mag_b};
    qbit = (trial >= {1'b0, data_i.mag_b});
    d_d.rem = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    d_d.num = {data_i.num[NUM_W-2:0], 1'b0};
    d_d.quo = {data_i.quo[NUM_W-2:0], qbit};
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o = d_q;
endmodule

[design/fxa_back.sv]
// output stage: rounding, sign and saturation of mul and div, result register
// depends on fxa_pkg and fxa_rsp_if
`timescale 1ns / 1ps

module fxa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  fxa_pkg::fxa_data_t data_i,
  fxa_rsp_if.source          rsp_o
);
  import fxa_pkg::*;

  localparam int Q_W = PROD_W - FRAC_W + 1;

  logic                     v_q;
  logic signed [DATA_W-1:0] res_q, res_d;
  logic                     cmp_q;
  logic                     ov_q, ov_d;
  logic [Q_W-1:0]           q_mul, q_div, q_sel;
  logic                     rnd_div;
  logic                     big;

  always_comb begin
    q_mul = Q_W'(data_i.prod[PROD_W-1:FRAC_W]) + Q_W'(data_i.prod[FRAC_W-1]);
    rnd_div = ({data_i.rem, 1'b0} >= {1'b0, data_i.mag_b});
    q_div = Q_W'(data_i.quo) + Q_W'(rnd_div);
    q_sel = (data_i.kind == KIND_MUL) ? q_mul : q_div;
    if (data_i.neg) begin
      big = (|q_sel[Q_W-1:DATA_W]) || (q_sel[DATA_W-1] && (|q_sel[DATA_W-2:0]));
    end else begin
      big = |q_sel[Q_W-1:DATA_W-1];
    end
    res_d = data_i.res;
    ov_d = data_i.ov;
    if ((data_i.kind == KIND_MUL) || (data_i.kind == KIND_DIV && !data_i.divz)) begin
      ov_d = big;
      if (big) begin
        res_d = data_i.neg ? MIN_V : MAX_V;
      end else begin
        res_d = data_i.neg ? DATA_W'(-q_sel[DATA_W-1:0]) : q_sel[DATA_W-1:0];
      end
    end
  end

  assign ready_o = !v_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
      cmp_q <= data_i.cmp;
      ov_q <= ov_d;
    end
  end

  assign rsp_o.valid = v_q;
  assign rsp_o.result = res_q;
  assign rsp_o.compare_true = cmp_q;
  assign rsp_o.overflow = ov_q;
endmodule

[design/fixed_point_q24_8_alu.sv]
// top level of the signed q24.8 fixed-point alu
// depends on fxa_pkg, fxa_req_if, fxa_rsp_if, fxa_front, fxa_mul, fxa_div_step, fxa_back
//
// usage:
// requests enter on req_i (kind, operand_a, operand_b) with a valid/ready
// handshake; each request yields exactly one result on rsp_o (result,
// compare_true, overflow), in request order.
// the pipeline has an input stage, a multiplier stage, 40 division stages
// (one quotient bit each) and an output register, and every request passes
// through all of them, whatever its kind.
// throughput is one request per cycle while rsp_o does not stall; every stage holds one request.
// each stage has its own valid bit and takes a new request when empty or
// when its content moves on, so bubbles close up while the receiver stalls
// and requests keep entering until the pipeline is full.
// a stall loses and repeats nothing.
// reset clears all valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu (
  input  logic      clk_i,
  input  logic      rst_ni,
  fxa_req_if.sink   req_i,
  fxa_rsp_if.source rsp_o
);
  import fxa_pkg::*;

  localparam int LINKS = DIV_STEPS + 2;

  logic      lv [LINKS];
  logic      lr [LINKS];
  fxa_data_t ld [LINKS];

  fxa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (lv[0]),
    .ready_i (lr[0]),
    .data_o  (ld[0])
  );

  fxa_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lv[0]),
    .ready_o (lr[0]),
    .data_i  (ld[0]),
    .valid_o (lv[1]),
    .ready_i (lr[1]),
    .data_o  (ld[1])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fxa_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lv[i+1]),
      .ready_o (lr[i+1]),
      .data_i  (ld[i+1]),
      .valid_o (lv[i+2]),
      .ready_i (lr[i+2]),
      .data_o  (ld[i+2])
    );
  end

  fxa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lv[LINKS-1]),
    .ready_o (lr[LINKS-1]),
    .data_i  (ld[LINKS-1]),
    .rsp_o   (rsp_o)
  );
endmodule
